// ----- rtl/biquad_pkg.sv -----
// biquad_pkg: shared types, register indexes and the control store of the biquad core.
// No dependencies; biquad_iir_filter_core refers to it by scoped names.
package biquad_pkg;

  localparam int ACC_BITS      = 48;
  localparam int COEF_BITS     = 32;
  localparam int NUM_COEFS     = 5;
  localparam int CFG_ADDR_BITS = 5;
  localparam int PC_BITS       = 4;

  typedef logic [2:0]         reg_idx_t;
  typedef logic [PC_BITS-1:0] pc_t;

  // register indexes on the configuration port, also the coefficient selects
  localparam reg_idx_t REG_B0 = 3'd0;
  localparam reg_idx_t REG_B1 = 3'd1;
  localparam reg_idx_t REG_B2 = 3'd2;
  localparam reg_idx_t REG_A1 = 3'd3;
  localparam reg_idx_t REG_A2 = 3'd4;

  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  typedef enum logic {MUL_X, MUL_Y} mul_src_t;
  typedef enum logic {ADD_A_P, ADD_A_ACC} add_a_t;
  typedef enum logic [1:0] {ADD_B_ZERO, ADD_B_D1, ADD_B_D2, ADD_B_P} add_b_t;
  typedef enum logic [1:0] {BR_NEVER, BR_NO_INPUT, BR_OUT_FULL, BR_ALWAYS} br_cond_t;

  // program steps
  localparam pc_t ST_WAIT    = 4'd0;
  localparam pc_t ST_MUL_B0  = 4'd1;
  localparam pc_t ST_ACC_Y   = 4'd2;
  localparam pc_t ST_ROUND   = 4'd3;
  localparam pc_t ST_OUT     = 4'd4;
  localparam pc_t ST_SUB_A1  = 4'd5;
  localparam pc_t ST_D1      = 4'd6;
  localparam pc_t ST_LOAD_B2 = 4'd7;
  localparam pc_t ST_D2      = 4'd8;

  typedef struct packed {
    logic      in_ready;
    logic      mul_en;
    mul_src_t  mul_src;
    reg_idx_t  coef_sel;
    add_a_t    add_a;
    add_b_t    add_b;
    logic      sub;
    logic      acc_we;
    logic      d1_we;
    logic      d2_we;
    logic      y_we;
    logic      out_load;
    br_cond_t  br_cond;
    pc_t       br_addr;
  } ctrl_t;

  // control store: one word per step
  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    w = '0;
    w.mul_src  = MUL_X;
    w.add_a    = ADD_A_P;
    w.add_b    = ADD_B_ZERO;
    w.br_cond  = BR_NEVER;
    w.br_addr  = ST_WAIT;
    unique case (pc)
      ST_WAIT: begin
        w.in_ready = 1'b1;
        w.br_cond  = BR_NO_INPUT;
        w.br_addr  = ST_WAIT;
      end
      ST_MUL_B0: begin
        w.mul_en   = 1'b1;
        w.coef_sel = REG_B0;
      end
      ST_ACC_Y: begin
        // acc = x*b0 + d1
        w.add_a    = ADD_A_P;
        w.add_b    = ADD_B_D1;
        w.acc_we   = 1'b1;
        w.mul_en   = 1'b1;
        w.coef_sel = REG_B1;
      end
      ST_ROUND: begin
        w.y_we     = 1'b1;
        w.add_a    = ADD_A_P;
        w.add_b    = ADD_B_ZERO;
        w.acc_we   = 1'b1;
      end
      ST_OUT: begin
        w.out_load = 1'b1;
        w.mul_en   = 1'b1;
        w.mul_src  = MUL_Y;
        w.coef_sel = REG_A1;
        w.br_cond  = BR_OUT_FULL;
        w.br_addr  = ST_OUT;
      end
      ST_SUB_A1: begin
        w.add_a    = ADD_A_ACC;
        w.add_b    = ADD_B_P;
        w.sub      = 1'b1;
        w.acc_we   = 1'b1;
      end
      ST_D1: begin
        w.add_a    = ADD_A_ACC;
        w.add_b    = ADD_B_D2;
        w.d1_we    = 1'b1;
        w.mul_en   = 1'b1;
        w.coef_sel = REG_B2;
      end
      ST_LOAD_B2: begin
        w.add_a    = ADD_A_P;
        w.add_b    = ADD_B_ZERO;
        w.acc_we   = 1'b1;
        w.mul_en   = 1'b1;
        w.mul_src  = MUL_Y;
        w.coef_sel = REG_A2;
      end
      ST_D2: begin
        w.add_a    = ADD_A_ACC;
        w.add_b    = ADD_B_P;
        w.sub      = 1'b1;
        w.d2_we    = 1'b1;
        w.br_cond  = BR_ALWAYS;
        w.br_addr  = ST_WAIT;
      end
      default: begin
        w.br_cond  = BR_ALWAYS;
        w.br_addr  = ST_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/biquad_iir_filter_core.sv -----
// biquad_iir_filter_core: second-order iir section, transposed direct form ii, fixed point.
// Depends on biquad_pkg for the control store, register indexes and constants.
//
// Usage:
//   in_*  : stream of samples, in_tdata holds sample_in (low SAMPLE_BITS bits).
//   out_* : stream of filtered samples, out_tdata holds sample_out.
//   cfg_* : apb-style port; b0, b1, b2, a1, a2 (signed, COEF_FRAC_BITS fraction bits)
//           at byte addresses 0x00, 0x04, 0x08, 0x0c, 0x10. pready is always high.
// A short program in a control store runs one shared multiplier and one saturating
// adder: 9 steps per item, and a new item is taken only once the program is back at its wait step.
// The multiplier handles five products per item one at a time.
// The result is loaded into the output register at the output step, after the accumulate and round steps.
// The output register holds a result while the receiver stalls; the program
// runs on and only waits at its output step if the previous result is still there.
// Reset clears the coefficients, both delay accumulators and the program counter;
// the block is ready to take an item as soon as reset is released.
// Accumulators saturate at 48 bits, the output saturates to SAMPLE_BITS bits.
module biquad_iir_filter_core #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_tvalid,
  output logic                                           in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]               in_tdata,   // sample_in
  output logic                                           out_tvalid,
  input  logic                                           out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]               out_tdata,  // sample_out
  input  logic                                           cfg_psel,
  input  logic                                           cfg_penable,
  input  logic                                           cfg_pwrite,
  input  logic [biquad_pkg::CFG_ADDR_BITS-1:0]           cfg_paddr,
  input  logic [biquad_pkg::COEF_BITS-1:0]               cfg_pwdata,
  output logic [biquad_pkg::COEF_BITS-1:0]               cfg_prdata,
  output logic                                           cfg_pready
);

  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int ACC_W  = biquad_pkg::ACC_BITS;
  localparam int CW     = biquad_pkg::COEF_BITS;
  localparam int PROD_W = SAMPLE_BITS + CW;
  localparam int WIDE_W = (PROD_W > ACC_W) ? PROD_W : ACC_W;
  localparam logic signed [ACC_W:0] ROUND_HALF = (ACC_W+1)'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W:0] Y_MAX =
    {{(ACC_W + 2 - SAMPLE_BITS){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W:0] Y_MIN = ~Y_MAX;

  // configuration
  logic signed [CW-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;
  logic                          cfg_wr;
  biquad_pkg::reg_idx_t          cfg_idx;

  // sequencer
  biquad_pkg::pc_t   pc_r, pc_nxt;
  biquad_pkg::ctrl_t cw;
  logic              br_taken;
  logic              out_full;
  logic              in_acc;

  // datapath
  logic signed [SAMPLE_BITS-1:0] x_r, y_r, y_nxt;
  logic signed [SAMPLE_BITS-1:0] mul_a;
  logic signed [CW-1:0]          coef_op;
  logic signed [PROD_W-1:0]      prod;
  logic signed [WIDE_W-1:0]      prod_w;
  logic [WIDE_W-ACC_W:0]         prod_hi;
  logic signed [ACC_W-1:0]       prod_sat;
  logic signed [ACC_W-1:0]       p_r, acc_r, d1_r, d2_r;
  logic signed [ACC_W-1:0]       add_a_op, add_b_op, add_res;
  logic signed [ACC_W:0]         add_sum;
  logic signed [ACC_W:0]         rnd_sum, rnd_shift;

  logic                          out_tvalid_r, out_tvalid_nxt;
  logic [SAMPLE_BITS-1:0]        out_data_r;
  logic                          out_load;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= '0;
      b1_r <= '0;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        biquad_pkg::REG_B0: b0_r <= cfg_pwdata;
        biquad_pkg::REG_B1: b1_r <= cfg_pwdata;
        biquad_pkg::REG_B2: b2_r <= cfg_pwdata;
        biquad_pkg::REG_A1: a1_r <= cfg_pwdata;
        biquad_pkg::REG_A2: a2_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      biquad_pkg::REG_B0: cfg_prdata = b0_r;
      biquad_pkg::REG_B1: cfg_prdata = b1_r;
      biquad_pkg::REG_B2: cfg_prdata = b2_r;
      biquad_pkg::REG_A1: cfg_prdata = a1_r;
      biquad_pkg::REG_A2: cfg_prdata = a2_r;
      default:            cfg_prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  assign cw        = biquad_pkg::ucode(pc_r);
  assign out_full  = out_tvalid_r && !out_tready;
  assign in_tready = cw.in_ready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    unique case (cw.br_cond)
      biquad_pkg::BR_NEVER:    br_taken = 1'b0;
      biquad_pkg::BR_NO_INPUT: br_taken = !in_tvalid;
      biquad_pkg::BR_OUT_FULL: br_taken = out_full;
      biquad_pkg::BR_ALWAYS:   br_taken = 1'b1;
      default:                 br_taken = 1'b1;
    endcase
    pc_nxt = br_taken ? cw.br_addr : biquad_pkg::pc_t'(pc_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= biquad_pkg::ST_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // ---------------- multiplier ----------------
  assign mul_a = (cw.mul_src == biquad_pkg::MUL_Y) ? y_r : x_r;

  always_comb begin
    unique case (cw.coef_sel)
      biquad_pkg::REG_B0: coef_op = b0_r;
      biquad_pkg::REG_B1: coef_op = b1_r;
      biquad_pkg::REG_B2: coef_op = b2_r;
      biquad_pkg::REG_A1: coef_op = a1_r;
      biquad_pkg::REG_A2: coef_op = a2_r;
      default:            coef_op = '0;
    endcase
  end

  assign prod    = mul_a * coef_op;
  assign prod_w  = WIDE_W'(prod);
  assign prod_hi = prod_w[WIDE_W-1:ACC_W-1];

  // product clamps to the accumulator range
  always_comb begin
    if ((&prod_hi) || !(|prod_hi)) begin
      prod_sat = prod_w[ACC_W-1:0];
    end else begin
      prod_sat = prod_w[WIDE_W-1] ? biquad_pkg::ACC_MIN : biquad_pkg::ACC_MAX;
    end
  end

  // ---------------- saturating adder ----------------
  assign add_a_op = (cw.add_a == biquad_pkg::ADD_A_ACC) ? acc_r : p_r;

  always_comb begin
    unique case (cw.add_b)
      biquad_pkg::ADD_B_ZERO: add_b_op = '0;
      biquad_pkg::ADD_B_D1:   add_b_op = d1_r;
      biquad_pkg::ADD_B_D2:   add_b_op = d2_r;
      biquad_pkg::ADD_B_P:    add_b_op = p_r;
      default:                add_b_op = '0;
    endcase
    if (cw.sub) begin
      add_sum = {add_a_op[ACC_W-1], add_a_op} - {add_b_op[ACC_W-1], add_b_op};
    end else begin
      add_sum = {add_a_op[ACC_W-1], add_a_op} + {add_b_op[ACC_W-1], add_b_op};
    end
    if (add_sum[ACC_W] != add_sum[ACC_W-1]) begin
      add_res = add_sum[ACC_W] ? biquad_pkg::ACC_MIN : biquad_pkg::ACC_MAX;
    end else begin
      add_res = add_sum[ACC_W-1:0];
    end
  end

  // ---------------- output rounding, half up ----------------
  always_comb begin
    rnd_sum   = {acc_r[ACC_W-1], acc_r} + ROUND_HALF;
    rnd_shift = rnd_sum >>> COEF_FRAC_BITS;
    priority if (rnd_shift > Y_MAX) begin
      y_nxt = Y_MAX[SAMPLE_BITS-1:0];
    end else if (rnd_shift < Y_MIN) begin
      y_nxt = Y_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_nxt = rnd_shift[SAMPLE_BITS-1:0];
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_tdata[SAMPLE_BITS-1:0];
    end
    if (cw.mul_en) begin
      p_r <= prod_sat;
    end
    if (cw.acc_we) begin
      acc_r <= add_res;
    end
    if (cw.y_we) begin
      y_r <= y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r <= '0;
      d2_r <= '0;
    end else begin
      if (cw.d1_we) begin
        d1_r <= add_res;
      end
      if (cw.d2_we) begin
        d2_r <= add_res;
      end
    end
  end

  // ---------------- output register ----------------
  assign out_load = cw.out_load && !out_full;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= y_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = DATA_W'(out_data_r);

  // ---------------- assertions ----------------
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= biquad_pkg::ST_D2)
    else $error("program counter left the program");

  a_valid_from_out_step: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && $past(rst_n) && $rose(out_tvalid_r)) |-> $past(pc_r) == biquad_pkg::ST_OUT)
    else $error("result raised outside the output step");

  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == biquad_pkg::ST_OUT && out_tvalid_r && !out_tready) |=>
      pc_r == biquad_pkg::ST_OUT)
    else $error("output step left while the previous result is pending");

  a_d1_update: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && $past(rst_n) && !$stable(d1_r)) |-> $past(pc_r) == biquad_pkg::ST_D1)
    else $error("first delay changed outside its update step");

  a_d2_update: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && $past(rst_n) && !$stable(d2_r)) |-> $past(pc_r) == biquad_pkg::ST_D2)
    else $error("second delay changed outside its update step");

endmodule

// ----- sim/biquad_iir_filter_core_tb.sv -----
// biquad_iir_filter_core_tb: self-checking bench for the biquad core, stream in and out,
// coefficients loaded over the apb-style port; a scoreboard class predicts every output.
// Depends on rtl/biquad_pkg.sv and rtl/biquad_iir_filter_core.sv.
`timescale 1ns / 100ps

module biquad_iir_filter_core_tb;

  localparam int          SAMPLE_BITS    = 16;
  localparam int          COEF_FRAC_BITS = 28;
  localparam int          DATA_BITS      = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int          DRAIN_CYCLES   = 12;
  localparam int          CYCLE_LIMIT    = 200000;
  localparam int          PHASE_ITEMS    = 65;
  localparam biquad_pkg::reg_idx_t REG_NONE = 3'd7;
  localparam logic [31:0] COEF_ONE       = 32'h1000_0000;
  localparam logic [31:0] COEF_HALF      = 32'h0800_0000;
  localparam logic [31:0] COEF_MAX       = 32'h7FFF_FFFF;
  localparam logic [31:0] COEF_MIN       = 32'h8000_0000;
  localparam logic [15:0] SAMPLE_MAX     = 16'h7FFF;
  localparam logic [15:0] SAMPLE_MIN     = 16'h8000;

  // predicts the filtered sample for each accepted item and holds the pending ones
  class filtered_sample_board;
    longint      coef_q[biquad_pkg::NUM_COEFS];
    longint      delay_one;
    longint      delay_two;
    logic [15:0] expected_y[$];
    int          errors;

    function new();
      foreach (coef_q[i]) coef_q[i] = 0;
      delay_one = 0;
      delay_two = 0;
      errors    = 0;
    endfunction

    function void load_coef(int idx, logic [31:0] v);
      logic signed [31:0] sv;
      sv = v;
      if (idx < biquad_pkg::NUM_COEFS) coef_q[idx] = sv;
    endfunction

    static function longint clip(longint v, longint hi);
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function void take_sample(logic [15:0] x_bits);
      longint acc_hi, x, acc, y, t;
      acc_hi = longint'(biquad_pkg::ACC_MAX);
      x      = longint'($signed(x_bits));
      acc = clip(clip(x * coef_q[biquad_pkg::REG_B0], acc_hi) + delay_one, acc_hi);
      y   = (acc + (64'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      y   = clip(y, (64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
      // feedback uses the saturated output, not the wide accumulator
      t         = clip(x * coef_q[biquad_pkg::REG_B1], acc_hi);
      t         = clip(t - clip(y * coef_q[biquad_pkg::REG_A1], acc_hi), acc_hi);
      delay_one = clip(t + delay_two, acc_hi);
      t         = clip(x * coef_q[biquad_pkg::REG_B2], acc_hi);
      delay_two = clip(t - clip(y * coef_q[biquad_pkg::REG_A2], acc_hi), acc_hi);
      expected_y.push_back(y[15:0]);
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= 10) $display("%0s", msg);
    endfunction

    function void check_filtered(logic [15:0] got);
      logic [15:0] want;
      if (expected_y.size() == 0) begin
        fail($sformatf("unexpected output item %0d", $signed(got)));
      end else begin
        want = expected_y.pop_front();
        if (got !== want)
          fail($sformatf("sample_out mismatch: expected %0d, got %0d",
                         $signed(want), $signed(got)));
      end
    endfunction

    function int pending();
      return expected_y.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [DATA_BITS-1:0] in_tdata;   // sample_in
  logic                 out_tvalid;
  logic                 out_tready;
  logic [DATA_BITS-1:0] out_tdata;  // sample_out
  logic                 cfg_psel;
  logic                 cfg_penable;
  logic                 cfg_pwrite;
  logic [biquad_pkg::CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [biquad_pkg::COEF_BITS-1:0]     cfg_pwdata;
  logic [biquad_pkg::COEF_BITS-1:0]     cfg_prdata;
  logic                 cfg_pready;

  filtered_sample_board sb;
  int unsigned          send_idle_pct = 0;
  int unsigned          recv_idle_pct = 0;
  int unsigned          recv_hold = 0;
  int unsigned          cycles = 0;

  biquad_iir_filter_core #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.take_sample(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_filtered(out_tdata);
  end

  // receiver: random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (recv_hold != 0) begin
      recv_hold  <= recv_hold - 1;
      out_tready <= (recv_hold == 1);
    end else if ($urandom_range(0, 99) < recv_idle_pct) begin
      recv_hold  <= $urandom_range(1, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_sample(input logic [15:0] x);
    in_tvalid <= 1'b1;
    in_tdata  <= x;
    do @(posedge clk); while (!in_tready);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic cfg_write(input biquad_pkg::reg_idx_t idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.load_coef(int'(idx), val);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // the program keeps updating the delays after the output step
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    // let the monitor note the item accepted at this edge first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_coefs(input logic [31:0] b0, input logic [31:0] b1,
                            input logic [31:0] b2, input logic [31:0] a1,
                            input logic [31:0] a2);
    wait_idle();
    cfg_write(biquad_pkg::REG_B0, b0);
    cfg_write(biquad_pkg::REG_B1, b1);
    cfg_write(biquad_pkg::REG_B2, b2);
    cfg_write(biquad_pkg::REG_A1, a1);
    cfg_write(biquad_pkg::REG_A2, a2);
  endtask

  // span 0 means any 32-bit value, otherwise uniform in +/- 2^span
  function automatic logic [31:0] rand_coef(input int unsigned span);
    if (span == 0) return $urandom;
    return $urandom_range(0, 32'd1 << (span + 1)) - (32'd1 << span);
  endfunction

  function automatic logic [15:0] rand_sample();
    unique case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      1:       return $urandom_range(0, 1) ? SAMPLE_MAX - 16'($urandom_range(0, 15))
                                           : SAMPLE_MIN + 16'($urandom_range(0, 15));
      2, 3:    return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned b_span;
    int unsigned a_span;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // coefficients are zero after reset
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(16'h1234);

    // pass-through
    load_coefs(COEF_ONE, 32'h0, 32'h0, 32'h0, 32'h0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(16'h0000);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    send_sample(16'h5555);
    send_sample(16'hAAAA);

    // b0, b1 and a1 at one half: rounding ties go up
    load_coefs(COEF_HALF, COEF_HALF, 32'h0, COEF_HALF, 32'h0);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    send_sample(16'h0003);
    send_sample(16'hFFFD);

    // extreme coefficients drive both accumulators and the output into saturation
    load_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
    // write to an unmapped register must change nothing
    cfg_write(REG_NONE, COEF_ONE);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(16'h0000);
    load_coefs(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(16'h0000);

    for (int ph = 0; ph < 6; ph++) begin
      b_span = (ph % 3 == 0) ? 0 : 27;
      a_span = (ph % 3 == 0) ? 0 : 28 - (ph % 2);
      load_coefs(rand_coef(b_span), rand_coef(b_span), rand_coef(b_span),
                 rand_coef(a_span), rand_coef(a_span));
      if (ph == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = (ph % 3) * 25;
        recv_idle_pct = ((ph + 1) % 3) * 25;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_sample(rand_sample());
        // sender holds off until the pipeline is empty
        if (ph == 1 && n == PHASE_ITEMS / 2) wait_idle();
      end
    end

    wait_idle();
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
